// File: hdl/xbt_pkg.sv
// Shared types and constants for the XML byte stream tokenizer.
// No dependencies; every module of the block imports this package.
package xbt_pkg;

  localparam int TEXT_CAP_DEF      = 256;
  localparam int NAME_CAP_DEF      = 64;
  localparam int ATTR_NAME_CAP_DEF = 64;

  localparam int MAX_EV = 6;
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  localparam logic [4:0] EV_CMT_BYTE   = 5'd0;
  localparam logic [4:0] EV_CMT_END    = 5'd1;
  localparam logic [4:0] EV_DT_BYTE    = 5'd2;
  localparam logic [4:0] EV_DT_END     = 5'd3;
  localparam logic [4:0] EV_PI_BYTE    = 5'd4;
  localparam logic [4:0] EV_PI_END     = 5'd5;
  localparam logic [4:0] EV_TEXT_BYTE  = 5'd6;
  localparam logic [4:0] EV_TEXT_END   = 5'd7;
  localparam logic [4:0] EV_TAG_BYTE   = 5'd8;
  localparam logic [4:0] EV_ANAME_BYTE = 5'd9;
  localparam logic [4:0] EV_AVAL_BYTE  = 5'd10;
  localparam logic [4:0] EV_ATTR_END   = 5'd11;
  localparam logic [4:0] EV_START_CLS  = 5'd12;
  localparam logic [4:0] EV_EMPTY_CLS  = 5'd13;
  localparam logic [4:0] EV_END_BYTE   = 5'd14;
  localparam logic [4:0] EV_END_CLS    = 5'd15;
  localparam logic [4:0] EV_ERROR      = 5'd16;

  localparam logic [1:0] ERR_SYNTAX    = 2'd0;
  localparam logic [1:0] ERR_NAME_LEN  = 2'd1;
  localparam logic [1:0] ERR_VALUE_LEN = 2'd2;
  localparam logic [1:0] ERR_DEPTH     = 2'd3;

  // All events caused by one document byte, as handed from parser to serializer.
  typedef struct packed {
    logic [2:0]              n;
    logic [MAX_EV-1:0][4:0]  kind;
    logic [MAX_EV-1:0][7:0]  data;
    logic [31:0]             line;
    logic [31:0]             col;
    logic [1:0]              cause;
  } xbt_pkt_t;

endpackage

// File: hdl/xbt_stream_if.sv
// Valid/ready channel interfaces for document bytes in and events out.
// Depends on nothing but the port widths given by the block's fields.
interface xbt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] doc_byte;
  logic       chunk_end;
  modport source(output valid, doc_byte, chunk_end, input ready);
  modport sink(input valid, doc_byte, chunk_end, output ready);
endinterface

interface xbt_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  event_kind;
  logic [7:0]  event_byte;
  logic        last_of_run;
  logic [31:0] line_number;
  logic [31:0] column_number;
  logic [1:0]  error_cause;
  modport source(output valid, event_kind, event_byte, last_of_run, line_number,
                 column_number, error_cause, input ready);
  modport sink(input valid, event_kind, event_byte, last_of_run, line_number,
               column_number, error_cause, output ready);
endinterface

// File: hdl/xbt_front.sv
// Parser front end: accepts one document byte per beat and turns it into a packet
// of events. Depends on xbt_pkg and xbt_in_if.
module xbt_front #(
  parameter int TEXT_CAP      = xbt_pkg::TEXT_CAP_DEF,
  parameter int NAME_CAP      = xbt_pkg::NAME_CAP_DEF,
  parameter int ATTR_NAME_CAP = xbt_pkg::ATTR_NAME_CAP_DEF
) (
  input  logic             clk,
  input  logic             rst,
  xbt_in_if.sink           in_ch,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  logic             q_full,
  output logic             push,
  output xbt_pkg::xbt_pkt_t pkt
);
  import xbt_pkg::*;

  localparam int TW = $clog2(TEXT_CAP + 1);
  localparam int NW = $clog2(NAME_CAP);
  localparam int AW = $clog2(ATTR_NAME_CAP);

  typedef enum logic [5:0] {
    PROLOG, LT, BANG, CMT_DASH, CMT, CMT_D1, CMT_D2,
    D_O, D_C, D_T, D_Y, D_P, D_E, DT_SP, DT_NAME0, DT_BODY,
    COND, COND_B1, COND_B2, PI, PI_Q,
    TAG_NAME, TAG_WS, ATTR_NAME, ATTR_WS, ATTR_EQ, VAL0, VAL, VAL_END, EMPTY,
    TEXT, TEXT_LT, TEXT_BANG, CD_1, CD_2, CD_3, CD_4, CD_5, CD_OPEN,
    CDATA, CD_B1, CD_B2, ETAG0, ETAG_NAME, ETAG_WS, EPILOG, EP_LT, EP_BANG
  } state_t;

  state_t      ps, ps_next;
  logic [15:0] nd, nd_next;
  logic [TW-1:0] tc, tc_next;
  logic [NW-1:0] nc, nc_next;
  logic [AW-1:0] anc, anc_next;
  logic [7:0]  pc, pc_next, qc, qc_next;
  logic        rs, rs_next, err, err_next;
  logic [31:0] line_count, column_count;
  logic        dsn;

  logic [2:0]             en;
  logic [MAX_EV-1:0][4:0] ek;
  logic [MAX_EV-1:0][7:0] eb;
  logic [1:0]             cause;
  logic       g_flush, g_space, g_take, g_setpc;
  logic [1:0] g_npre;
  logic [2:0] g_need;
  logic [7:0] g_pre;
  logic [4:0] g_bk, g_ek;
  logic [7:0] c;
  logic       accept;

  function automatic logic is_ws(input logic [7:0] x);
    return x == 8'h20 || x == 8'h09 || x == 8'h0d || x == 8'h0a;
  endfunction

  function automatic logic is_char(input logic [7:0] x);
    return x == 8'h09 || x == 8'h0a || x == 8'h0d || x >= 8'h20;
  endfunction

  function automatic logic name_start(input logic [7:0] x, input logic d);
    return x == ":" || x == "_" || (x >= "A" && x <= "Z") || (x >= "a" && x <= "z") ||
           (d && x >= "0" && x <= "9") || (x >= 8'hc0 && x <= 8'hd6) ||
           (x >= 8'hd8 && x <= 8'hf6) || x >= 8'hf8;
  endfunction

  function automatic logic name_char(input logic [7:0] x, input logic d);
    return name_start(x, d) || x == "-" || x == "." || (x >= "0" && x <= "9") || x == 8'hb7;
  endfunction

  function automatic logic letter_is(input logic [7:0] x, input logic [7:0] u);
    return x == u || x == u + 8'd32;
  endfunction

  assign c = in_ch.doc_byte;
  assign in_ch.ready = !q_full;
  assign accept = in_ch.valid && !q_full;

  always_comb begin
    ps_next = ps; nd_next = nd; tc_next = tc; nc_next = nc; anc_next = anc;
    pc_next = pc; qc_next = qc; rs_next = rs; err_next = err;
    en = 3'd0; ek = '0; eb = '0; cause = ERR_SYNTAX;
    g_flush = 1'b0; g_space = 1'b0; g_take = 1'b0; g_setpc = 1'b0;
    g_npre = 2'd0; g_need = 3'd0; g_pre = 8'd0; g_bk = EV_TEXT_BYTE; g_ek = EV_TEXT_END;
    if (!err) begin
      case (ps)
        PROLOG: begin
          if (c == "<") ps_next = LT;
          else if (!is_ws(c)) err_next = 1'b1;
        end
        LT: begin
          if (name_start(c, dsn)) begin
            rs_next = 1'b1;
            ek[en] = EV_TAG_BYTE; eb[en] = c; en = en + 3'd1;
            nc_next = NW'(1); ps_next = TAG_NAME;
          end else if (c == "!") ps_next = BANG;
          else if (c == "?") begin
            tc_next = '0; pc_next = 8'd0; ps_next = PI;
          end else err_next = 1'b1;
        end
        BANG: begin
          if (c == "-") ps_next = CMT_DASH;
          else if (letter_is(c, "D")) ps_next = D_O;
          else if (c == "[") ps_next = COND;
          else err_next = 1'b1;
        end
        CMT_DASH: begin
          if (c == "-") begin
            tc_next = '0; pc_next = 8'd0; ps_next = CMT;
          end else err_next = 1'b1;
        end
        CMT: begin
          if (c == "-") ps_next = CMT_D1;
          else if (is_char(c)) begin
            g_bk = EV_CMT_BYTE; g_ek = EV_CMT_END; g_setpc = 1'b1;
            if (!is_ws(c)) begin
              g_flush = 1'b1; g_space = 1'b1; g_need = 3'd2; g_take = 1'b1;
            end
          end else err_next = 1'b1;
        end
        CMT_D1: begin
          if (c == "-") ps_next = CMT_D2;
          else if (is_char(c)) begin
            g_bk = EV_CMT_BYTE; g_ek = EV_CMT_END; g_setpc = 1'b1; g_flush = 1'b1;
            g_space = 1'b1; g_need = 3'd3; g_pre = "-"; g_npre = 2'd1;
            g_take = !is_ws(c); ps_next = CMT;
          end else err_next = 1'b1;
        end
        CMT_D2: begin
          if (c == ">") begin
            if (tc != '0) begin
              ek[en] = EV_CMT_END; en = en + 3'd1;
            end
            if (!rs) ps_next = PROLOG;
            else if (nd != 16'd0) begin
              tc_next = '0; pc_next = 8'd0; ps_next = TEXT;
            end else ps_next = EPILOG;
          end else if (c == "-") begin
            g_bk = EV_CMT_BYTE; g_ek = EV_CMT_END; g_setpc = 1'b1; g_flush = 1'b1;
            g_space = 1'b1; g_need = 3'd2; g_pre = "-"; g_npre = 2'd1;
          end else if (is_char(c)) begin
            g_bk = EV_CMT_BYTE; g_ek = EV_CMT_END; g_setpc = 1'b1; g_flush = 1'b1;
            g_space = 1'b1; g_need = 3'd4; g_pre = "-"; g_npre = 2'd2;
            g_take = !is_ws(c); ps_next = CMT;
          end else err_next = 1'b1;
        end
        D_O: if (letter_is(c, "O")) ps_next = D_C; else err_next = 1'b1;
        D_C: if (letter_is(c, "C")) ps_next = D_T; else err_next = 1'b1;
        D_T: if (letter_is(c, "T")) ps_next = D_Y; else err_next = 1'b1;
        D_Y: if (letter_is(c, "Y")) ps_next = D_P; else err_next = 1'b1;
        D_P: if (letter_is(c, "P")) ps_next = D_E; else err_next = 1'b1;
        D_E: if (letter_is(c, "E")) ps_next = DT_SP; else err_next = 1'b1;
        DT_SP: if (is_ws(c)) ps_next = DT_NAME0; else err_next = 1'b1;
        DT_NAME0: begin
          if (name_start(c, dsn)) begin
            ek[en] = EV_DT_BYTE; eb[en] = c; en = en + 3'd1;
            tc_next = TW'(1); pc_next = c; ps_next = DT_BODY;
          end else if (!is_ws(c)) err_next = 1'b1;
        end
        DT_BODY: begin
          if (c == ">") begin
            ek[en] = EV_DT_END; en = en + 3'd1; ps_next = PROLOG;
          end else if (is_char(c)) begin
            g_bk = EV_DT_BYTE; g_ek = EV_DT_END; g_setpc = 1'b1;
            if (!is_ws(c)) begin
              g_flush = 1'b1; g_space = 1'b1; g_need = 3'd2; g_take = 1'b1;
            end
          end else err_next = 1'b1;
        end
        COND: begin
          if (c == "]") ps_next = COND_B1;
          else if (!is_char(c)) err_next = 1'b1;
        end
        COND_B1: begin
          if (c == "]") ps_next = COND_B2;
          else if (is_char(c)) ps_next = COND;
          else err_next = 1'b1;
        end
        COND_B2: begin
          if (c == ">") ps_next = PROLOG;
          else if (is_char(c)) begin
            if (c != "]") ps_next = COND;
          end else err_next = 1'b1;
        end
        PI: begin
          if (c == "?") ps_next = PI_Q;
          else if (is_char(c)) begin
            g_bk = EV_PI_BYTE; g_ek = EV_PI_END; g_setpc = 1'b1;
            if (!is_ws(c)) begin
              g_flush = 1'b1; g_space = 1'b1; g_need = 3'd2; g_take = 1'b1;
            end
          end else err_next = 1'b1;
        end
        PI_Q: begin
          if (c == ">") begin
            if (tc != '0) begin
              ek[en] = EV_PI_END; en = en + 3'd1;
            end
            if (!rs) ps_next = PROLOG;
            else if (nd != 16'd0) begin
              tc_next = '0; pc_next = 8'd0; ps_next = TEXT;
            end else ps_next = EPILOG;
          end else if (c == "?") begin
            g_bk = EV_PI_BYTE; g_ek = EV_PI_END; g_setpc = 1'b1; g_flush = 1'b1;
            g_space = 1'b1; g_need = 3'd2; g_pre = "?"; g_npre = 2'd1;
          end else if (is_char(c)) begin
            g_bk = EV_PI_BYTE; g_ek = EV_PI_END; g_setpc = 1'b1; g_flush = 1'b1;
            g_space = 1'b1; g_need = 3'd3; g_pre = "?"; g_npre = 2'd1;
            g_take = !is_ws(c); ps_next = PI;
          end else err_next = 1'b1;
        end
        TAG_NAME, TAG_WS, VAL_END: begin
          if (ps == TAG_NAME && is_ws(c)) ps_next = TAG_WS;
          else if (ps == VAL_END && is_ws(c)) ps_next = TAG_WS;
          else if (ps == TAG_WS && name_start(c, dsn)) begin
            ek[en] = EV_ANAME_BYTE; eb[en] = c; en = en + 3'd1;
            anc_next = AW'(1); ps_next = ATTR_NAME;
          end else if (c == ">") begin
            if (nd == 16'hffff) begin
              err_next = 1'b1; cause = ERR_DEPTH;
            end else begin
              ek[en] = EV_START_CLS; en = en + 3'd1;
              nd_next = nd + 16'd1; tc_next = '0; pc_next = 8'd0; ps_next = TEXT;
            end
          end else if (c == "/") ps_next = EMPTY;
          else if (ps == TAG_NAME && name_char(c, dsn)) begin
            if (32'(nc) + 32'd1 >= 32'(NAME_CAP)) begin
              err_next = 1'b1; cause = ERR_NAME_LEN;
            end else begin
              ek[en] = EV_TAG_BYTE; eb[en] = c; en = en + 3'd1; nc_next = nc + NW'(1);
            end
          end else if (!(ps == TAG_WS && is_ws(c))) err_next = 1'b1;
        end
        ATTR_NAME: begin
          if (is_ws(c)) ps_next = ATTR_WS;
          else if (c == "=") ps_next = ATTR_EQ;
          else if (name_char(c, dsn)) begin
            if (32'(anc) + 32'd1 >= 32'(ATTR_NAME_CAP)) begin
              err_next = 1'b1; cause = ERR_NAME_LEN;
            end else begin
              ek[en] = EV_ANAME_BYTE; eb[en] = c; en = en + 3'd1; anc_next = anc + AW'(1);
            end
          end else err_next = 1'b1;
        end
        ATTR_WS: begin
          if (c == "=") ps_next = ATTR_EQ;
          else if (!is_ws(c)) err_next = 1'b1;
        end
        ATTR_EQ: begin
          if (c == "\"" || c == "'") begin
            qc_next = c; ps_next = VAL0;
          end else if (!is_ws(c)) err_next = 1'b1;
        end
        VAL0, VAL: begin
          if (c == qc) begin
            ek[en] = EV_ATTR_END; en = en + 3'd1; ps_next = VAL_END;
          end else if (is_char(c)) begin
            if (ps == VAL0) begin
              ek[en] = EV_AVAL_BYTE; eb[en] = c; en = en + 3'd1;
              tc_next = TW'(1); ps_next = VAL;
            end else if (32'(tc) + 32'd1 > 32'(TEXT_CAP)) begin
              err_next = 1'b1; cause = ERR_VALUE_LEN;
            end else begin
              ek[en] = EV_AVAL_BYTE; eb[en] = c; en = en + 3'd1; tc_next = tc + TW'(1);
            end
          end else err_next = 1'b1;
        end
        EMPTY: begin
          if (c == ">") begin
            ek[en] = EV_EMPTY_CLS; en = en + 3'd1;
            if (nd != 16'd0) begin
              tc_next = '0; pc_next = 8'd0; ps_next = TEXT;
            end else ps_next = EPILOG;
          end else err_next = 1'b1;
        end
        TEXT: begin
          if (c == "<") begin
            if (tc != '0) begin
              ek[en] = EV_TEXT_END; en = en + 3'd1;
            end
            ps_next = TEXT_LT;
          end else begin
            g_setpc = 1'b1;
            if (!is_ws(c)) begin
              g_flush = 1'b1; g_space = 1'b1; g_need = 3'd2; g_take = 1'b1;
            end
          end
        end
        TEXT_LT: begin
          if (name_start(c, dsn)) begin
            ek[en] = EV_TAG_BYTE; eb[en] = c; en = en + 3'd1;
            nc_next = NW'(1); ps_next = TAG_NAME;
          end else if (c == "!") ps_next = TEXT_BANG;
          else if (c == "?") begin
            tc_next = '0; pc_next = 8'd0; ps_next = PI;
          end else if (c == "/") ps_next = ETAG0;
          else err_next = 1'b1;
        end
        TEXT_BANG: begin
          if (c == "[") ps_next = CD_1;
          else if (c == "-") ps_next = CMT_DASH;
          else err_next = 1'b1;
        end
        CD_1: if (letter_is(c, "C")) ps_next = CD_2; else err_next = 1'b1;
        CD_2: if (letter_is(c, "D")) ps_next = CD_3; else err_next = 1'b1;
        CD_3: if (letter_is(c, "A")) ps_next = CD_4; else err_next = 1'b1;
        CD_4: if (letter_is(c, "T")) ps_next = CD_5; else err_next = 1'b1;
        CD_5: if (letter_is(c, "A")) ps_next = CD_OPEN; else err_next = 1'b1;
        CD_OPEN: begin
          if (c == "[") begin
            if (is_ws(pc) && tc != '0) begin
              ek[en] = EV_TEXT_BYTE; eb[en] = 8'h20; en = en + 3'd1; tc_next = TW'(1);
            end else tc_next = '0;
            ps_next = CDATA;
          end else err_next = 1'b1;
        end
        CDATA: begin
          if (c == "]") ps_next = CD_B1;
          else if (is_char(c)) begin
            g_flush = 1'b1; g_need = 3'd1; g_take = 1'b1;
          end else err_next = 1'b1;
        end
        CD_B1: begin
          if (c == "]") ps_next = CD_B2;
          else if (is_char(c)) begin
            g_flush = 1'b1; g_need = 3'd2; g_pre = "]"; g_npre = 2'd1; g_take = 1'b1;
            ps_next = CDATA;
          end else err_next = 1'b1;
        end
        CD_B2: begin
          if (c == ">") begin
            pc_next = 8'd0; ps_next = TEXT;
          end else if (c == "]") begin
            g_flush = 1'b1; g_need = 3'd1; g_pre = "]"; g_npre = 2'd1;
          end else if (is_char(c)) begin
            g_flush = 1'b1; g_need = 3'd3; g_pre = "]"; g_npre = 2'd2; g_take = 1'b1;
            ps_next = CDATA;
          end else err_next = 1'b1;
        end
        ETAG0: begin
          if (name_start(c, dsn)) begin
            ek[en] = EV_END_BYTE; eb[en] = c; en = en + 3'd1;
            nc_next = NW'(1); ps_next = ETAG_NAME;
          end else err_next = 1'b1;
        end
        ETAG_NAME, ETAG_WS: begin
          if (c == ">") begin
            ek[en] = EV_END_CLS; en = en + 3'd1;
            if (nd > 16'd1) begin
              nd_next = nd - 16'd1; tc_next = '0; pc_next = 8'd0; ps_next = TEXT;
            end else begin
              nd_next = 16'd0; ps_next = EPILOG;
            end
          end else if (ps == ETAG_NAME && name_char(c, dsn)) begin
            if (32'(nc) + 32'd1 >= 32'(NAME_CAP)) begin
              err_next = 1'b1; cause = ERR_NAME_LEN;
            end else begin
              ek[en] = EV_END_BYTE; eb[en] = c; en = en + 3'd1; nc_next = nc + NW'(1);
            end
          end else if (is_ws(c)) ps_next = ETAG_WS;
          else err_next = 1'b1;
        end
        EPILOG: begin
          if (c == "<") ps_next = EP_LT;
          else if (!is_ws(c)) err_next = 1'b1;
        end
        EP_LT: begin
          if (c == "!") ps_next = EP_BANG;
          else if (c == "?") begin
            tc_next = '0; pc_next = 8'd0; ps_next = PI;
          end else err_next = 1'b1;
        end
        EP_BANG: if (c == "-") ps_next = CMT_DASH; else err_next = 1'b1;
        default: err_next = 1'b1;
      endcase

      // Shared text path: segment flush, collapsed space, prefix bytes, kept byte.
      if (!err_next) begin
        if (g_flush && 32'(tc_next) + 32'(g_need) > 32'(TEXT_CAP)) begin
          ek[en] = g_ek; en = en + 3'd1; tc_next = '0;
        end
        if (g_space && is_ws(pc) && tc_next != '0) begin
          ek[en] = g_bk; eb[en] = 8'h20; en = en + 3'd1; tc_next = tc_next + TW'(1);
        end
        if (g_npre != 2'd0) begin
          ek[en] = g_bk; eb[en] = g_pre; en = en + 3'd1; tc_next = tc_next + TW'(1);
        end
        if (g_npre == 2'd2) begin
          ek[en] = g_bk; eb[en] = g_pre; en = en + 3'd1; tc_next = tc_next + TW'(1);
        end
        if (g_take) begin
          ek[en] = g_bk; eb[en] = c; en = en + 3'd1; tc_next = tc_next + TW'(1);
        end
        if (g_setpc) pc_next = c;
      end else begin
        en = 3'd1; ek = '0; eb = '0; ek[0] = EV_ERROR;
      end
    end
  end

  always_comb begin
    pkt.n     = en;
    pkt.kind  = ek;
    pkt.data  = eb;
    pkt.line  = line_count;
    pkt.col   = column_count;
    pkt.cause = err_next ? cause : ERR_SYNTAX;
  end

  assign push = accept && en != 3'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ps <= PROLOG; nd <= '0; tc <= '0; nc <= '0; anc <= '0; pc <= '0; qc <= '0;
      rs <= 1'b0; err <= 1'b0; line_count <= 32'd1; column_count <= 32'd1; dsn <= 1'b0;
    end else begin
      if (cfg_wr_en) dsn <= cfg_wr_data;
      if (accept && !err) begin
        err <= err_next;
        if (!err_next) begin
          ps <= ps_next; nd <= nd_next; tc <= tc_next; nc <= nc_next; anc <= anc_next;
          pc <= pc_next; qc <= qc_next; rs <= rs_next;
          if (c == 8'h0a) begin
            if (line_count != 32'hffff_ffff) line_count <= line_count + 32'd1;
            column_count <= 32'd1;
          end else if (column_count != 32'hffff_ffff) begin
            column_count <= column_count + 32'd1;
          end
        end
      end
    end
  end

  a_quiet_after_error: assert property (@(posedge clk) disable iff (rst) err |-> !push)
    else $error("event packet pushed after a sticky error");
  a_error_alone: assert property (@(posedge clk) disable iff (rst)
    $rose(err) |-> $past(push && pkt.n == 3'd1 && pkt.kind[0] == EV_ERROR))
    else $error("error raised without a lone error event");
  a_pkt_size: assert property (@(posedge clk) disable iff (rst)
    push |-> pkt.n <= 3'(MAX_EV))
    else $error("event packet larger than the event limit");

endmodule

// File: hdl/xbt_queue.sv
// Small packet FIFO between the parser and the event serializer.
// Depends on xbt_pkg.
module xbt_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  xbt_pkg::xbt_pkt_t wr_pkt,
  input  logic              pop,
  output xbt_pkg::xbt_pkt_t head,
  output logic              full,
  output logic              empty
);
  import xbt_pkg::*;

  xbt_pkt_t       mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;

  assign full  = count == (QAW+1)'(QDEPTH);
  assign empty = count == '0;
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) mem[wr_ptr] <= wr_pkt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0; rd_ptr <= '0; count <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + QAW'(1);
      if (pop && !empty) rd_ptr <= rd_ptr + QAW'(1);
      count <= count + (QAW+1)'(push && !full) - (QAW+1)'(pop && !empty);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("pop from an empty queue");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    count != $past(count) |-> $past(push) || $past(pop))
    else $error("queue count moved without a push or pop");

endmodule

// File: hdl/xbt_back.sv
// Event serializer: walks the head packet and drives one event per output beat
// from an output register. Depends on xbt_pkg and xbt_out_if.
module xbt_back (
  input  logic              clk,
  input  logic              rst,
  input  xbt_pkg::xbt_pkt_t head,
  input  logic              empty,
  output logic              pop,
  xbt_out_if.source         out_ch
);
  import xbt_pkg::*;

  logic [2:0] idx;
  logic       load, last;

  assign load = !empty && (!out_ch.valid || out_ch.ready);
  assign last = idx == head.n - 3'd1;
  assign pop  = load && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      idx <= '0;
    end else begin
      if (load) begin
        out_ch.valid <= 1'b1;
        idx <= last ? 3'd0 : idx + 3'd1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.event_kind    <= head.kind[idx];
      out_ch.event_byte    <= head.data[idx];
      out_ch.last_of_run   <= last;
      out_ch.line_number   <= head.line;
      out_ch.column_number <= head.col;
      out_ch.error_cause   <= (head.kind[idx] == EV_ERROR) ? head.cause : ERR_SYNTAX;
    end
  end

  a_idx_in_packet: assert property (@(posedge clk) disable iff (rst)
    !empty |-> idx < head.n)
    else $error("serializer index beyond packet size");
  a_error_ends_run: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.event_kind == EV_ERROR |-> out_ch.last_of_run)
    else $error("error event not last of its run");
  a_cause_only_on_error: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.event_kind != EV_ERROR |-> out_ch.error_cause == ERR_SYNTAX)
    else $error("error cause set on a non-error event");

endmodule

// File: hdl/xml_byte_stream_tokenizer.sv
// Top level of the XML byte stream tokenizer: parser, packet queue, serializer.
// Depends on xbt_pkg, xbt_stream_if, xbt_front, xbt_queue and xbt_back.
//
// Document bytes arrive on in_ch, one per beat; token events leave on out_ch,
// one per beat, each carrying the line and column of the byte that caused it.
// The last event of a byte has last_of_run set; bytes that cause no event
// produce no beat. The parser takes a byte every cycle while its packet queue
// (four packets) has room, so input runs at one byte per cycle.
// A byte's events pass through the packet queue and then the output register
// before they reach out_ch. The serializer sends one event per cycle while
// out_ch is ready; a byte that causes any event causes one to five.
// When out_ch stalls, the output register holds its event, the queue fills and
// in_ch.ready drops; nothing is lost. A syntax or limit error gives one error
// event and then every later byte is consumed silently until reset.
// Reset (rst, synchronous) returns the parser to the prolog, line and column
// to 1, clears the error and the queue, and sets digits_start_names to 0.
// cfg_wr_en/cfg_wr_data write digits_start_names; write it only while idle.
module xml_byte_stream_tokenizer #(
  parameter int TEXT_CAP      = xbt_pkg::TEXT_CAP_DEF,
  parameter int NAME_CAP      = xbt_pkg::NAME_CAP_DEF,
  parameter int ATTR_NAME_CAP = xbt_pkg::ATTR_NAME_CAP_DEF
) (
  input  logic       clk,
  input  logic       rst,
  xbt_in_if.sink     in_ch,
  xbt_out_if.source  out_ch,
  input  logic       cfg_wr_en,
  input  logic       cfg_wr_data
);
  import xbt_pkg::*;

  xbt_pkt_t wr_pkt, head;
  logic     push, pop, full, empty;

  xbt_front #(
    .TEXT_CAP(TEXT_CAP), .NAME_CAP(NAME_CAP), .ATTR_NAME_CAP(ATTR_NAME_CAP)
  ) u_front (
    .clk(clk), .rst(rst), .in_ch(in_ch), .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data), .q_full(full), .push(push), .pkt(wr_pkt)
  );

  xbt_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wr_pkt(wr_pkt), .pop(pop),
    .head(head), .full(full), .empty(empty)
  );

  xbt_back u_back (
    .clk(clk), .rst(rst), .head(head), .empty(empty), .pop(pop), .out_ch(out_ch)
  );

endmodule
